>>> design/cof_pkg.sv
// cof_pkg: shared types and constants of the console output filter.
// Holds the escape sequences, the token passed from front to back, and the state enums.
// Depends on nothing; cof_front, cof_queue, cof_back and console_output_filter use it.
`default_nettype none

package cof_pkg;

    localparam int WRAP_LEN       = 5;
    localparam int DETACH_SEQ_LEN = 16;

    localparam logic [7:0] ESC = 8'h1B;

    // ESC [ ? 7 l  (wrap off) and ESC [ ? 7 h  (wrap on)
    localparam logic [7:0] WRAP_OFF [WRAP_LEN] = '{8'h1B, 8'h5B, 8'h3F, 8'h37, 8'h6C};
    localparam logic [7:0] WRAP_ON  [WRAP_LEN] = '{8'h1B, 8'h5B, 8'h3F, 8'h37, 8'h68};

    // ESC ] s c o r p i - d e t a c h BEL
    localparam logic [7:0] DETACH_PAT [DETACH_SEQ_LEN] = '{
        8'h1B, 8'h5D, 8'h73, 8'h63, 8'h6F, 8'h72, 8'h70, 8'h69,
        8'h2D, 8'h64, 8'h65, 8'h74, 8'h61, 8'h63, 8'h68, 8'h07
    };

    // One byte handed from the front stage to the back stage.
    // has_byte low marks an end-of-request marker that carries no byte.
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       eos;
    } t_token;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

    typedef enum logic {
        FRONT_IDLE,
        FRONT_ISSUE
    } t_front_state;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_REPLAY,
        BACK_FLUSH
    } t_back_state;

endpackage

`default_nettype wire

>>> design/cof_front.sv
// cof_front: accepts requests and rewrites the wrap-disable sequence into wrap-enable.
// Emits one token per cycle into the queue while it is not full; the last token of a request carries eos.
// Depends on cof_pkg.
`default_nettype none

module cof_front (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [7:0]             i_in_byte,
    input  wire logic                   i_end_of_read,
    input  wire cof_pkg::t_queue_status i_q_status,
    output logic                        o_push,
    output cof_pkg::t_token             o_token
);

    cof_pkg::t_front_state r_state;
    cof_pkg::t_front_state n_state;

    logic [2:0] r_wcnt;
    logic [7:0] r_list [cof_pkg::WRAP_LEN];
    logic [2:0] r_n;
    logic [2:0] r_idx;

    logic       accept;
    logic       match;
    logic       a_on;
    logic       hc;
    logic [2:0] a_len;
    logic [2:0] b_len;
    logic [2:0] keep_cnt;
    logic [2:0] plan_n;
    logic [2:0] boff;
    logic [7:0] plan [cof_pkg::WRAP_LEN];
    logic       last_tok;

    assign accept   = i_in_valid && o_in_ready;
    assign last_tok = (r_n == 3'd0) || (r_idx == r_n - 3'd1);

    // Plan the bytes this request releases: held prefix or replacement, the byte, flush.
    always_comb begin
        match    = (i_in_byte == cof_pkg::WRAP_OFF[r_wcnt]);
        a_len    = 3'd0;
        a_on     = 1'b0;
        hc       = 1'b0;
        keep_cnt = 3'd0;
        boff     = 3'd0;
        if (match && r_wcnt == 3'(cof_pkg::WRAP_LEN - 1)) begin
            a_len = 3'(cof_pkg::WRAP_LEN);
            a_on  = 1'b1;
        end else if (match) begin
            keep_cnt = r_wcnt + 3'd1;
        end else begin
            a_len = r_wcnt;
            if (r_wcnt != 3'd0 && i_in_byte == cof_pkg::ESC) begin
                keep_cnt = 3'd1;
            end else begin
                hc = 1'b1;
            end
        end
        b_len  = i_end_of_read ? keep_cnt : 3'd0;
        plan_n = a_len + {2'b00, hc} + b_len;
        for (int i = 0; i < cof_pkg::WRAP_LEN; i++) begin
            boff = 3'(i) - a_len - {2'b00, hc};
            if (3'(i) < a_len) begin
                plan[i] = a_on ? cof_pkg::WRAP_ON[i] : cof_pkg::WRAP_OFF[i];
            end else if (3'(i) == a_len && hc) begin
                plan[i] = i_in_byte;
            end else if (boff < 3'(cof_pkg::WRAP_LEN)) begin
                plan[i] = cof_pkg::WRAP_OFF[boff];
            end else begin
                plan[i] = 8'h00;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cof_pkg::FRONT_IDLE: begin
                if (accept) begin
                    n_state = cof_pkg::FRONT_ISSUE;
                end
            end
            cof_pkg::FRONT_ISSUE: begin
                if (o_push && last_tok) begin
                    n_state = cof_pkg::FRONT_IDLE;
                end
            end
            default: n_state = cof_pkg::FRONT_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready       = (r_state == cof_pkg::FRONT_IDLE);
        o_push           = (r_state == cof_pkg::FRONT_ISSUE) && !i_q_status.full;
        o_token.data     = r_list[r_idx];
        o_token.has_byte = (r_n != 3'd0);
        o_token.eos      = last_tok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cof_pkg::FRONT_IDLE;
            r_wcnt  <= 3'd0;
            r_n     <= 3'd0;
            r_idx   <= 3'd0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_wcnt <= i_end_of_read ? 3'd0 : keep_cnt;
                r_n    <= plan_n;
                r_idx  <= 3'd0;
            end else if (o_push && !last_tok) begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_list <= plan;
        end
    end

endmodule

`default_nettype wire

>>> design/cof_queue.sv
// cof_queue: small token queue between the front and back stages.
// Register-based ring with a fill count; depth set by DEPTH.
// Depends on cof_pkg.
`default_nettype none

module cof_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire cof_pkg::t_token        i_data,
    input  wire logic                   i_pop,
    output cof_pkg::t_token             o_data,
    output cof_pkg::t_queue_status      o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cof_pkg::t_token r_mem [DEPTH];
    logic [AW-1:0]   r_wptr;
    logic [AW-1:0]   r_rptr;
    logic [CW-1:0]   r_count;

    assign o_data         = r_mem[r_rptr];
    assign o_status.empty = (r_count == CW'(0));
    assign o_status.full  = (r_count == CW'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> design/cof_back.sv
// cof_back: detach-sequence matcher and result output register.
// Replays a held prefix one byte a cycle while the output is free, holds the newest result until the
// end of its request is known, and drives the output channel. Depends on cof_pkg.
`default_nettype none

module cof_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire cof_pkg::t_token        i_token,
    input  wire cof_pkg::t_queue_status i_q_status,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [7:0]                  o_out_byte,
    output logic                        o_detach_seen,
    output logic                        o_last_of_run
);

    cof_pkg::t_back_state r_state;
    cof_pkg::t_back_state n_state;

    logic [3:0] r_dcnt,        n_dcnt;
    logic       r_detached,    n_detached;
    logic [7:0] r_c,           n_c;
    logic [3:0] r_rcnt,        n_rcnt;
    logic [3:0] r_ridx,        n_ridx;
    logic       r_eos,         n_eos;
    logic       r_pend_valid,  n_pend_valid;
    logic [7:0] r_pend_byte,   n_pend_byte;
    logic       r_pend_det,    n_pend_det;
    logic       r_out_valid,   n_out_valid;
    logic [7:0] r_out_byte,    n_out_byte;
    logic       r_out_det,     n_out_det;
    logic       r_out_last,    n_out_last;

    logic       out_free;
    logic       take;
    logic       rep_step;
    logic       hit;
    logic       skip;
    logic       act_adv;
    logic       act_det;
    logic       act_pass;
    logic       act_replay;
    logic       rep_char;
    logic       rep_last_esc;
    logic       gen_valid;
    logic [7:0] gen_byte;
    logic       tok_end;
    logic       step_end;
    logic       out_wr;
    logic       out_last;

    always_comb begin
        out_free     = !r_out_valid || i_out_ready;
        take         = (r_state == cof_pkg::BACK_IDLE) && !i_q_status.empty && out_free;
        rep_step     = (r_state == cof_pkg::BACK_REPLAY) && out_free;
        hit          = (i_token.data == cof_pkg::DETACH_PAT[r_dcnt]);
        skip         = !i_token.has_byte || r_detached;
        act_adv      = take && !skip && hit && (r_dcnt != 4'(cof_pkg::DETACH_SEQ_LEN - 1));
        act_det      = take && !skip && hit && (r_dcnt == 4'(cof_pkg::DETACH_SEQ_LEN - 1));
        act_pass     = take && !skip && !hit && (r_dcnt == 4'd0);
        act_replay   = take && !skip && !hit && (r_dcnt != 4'd0);
        rep_char     = (r_ridx == r_rcnt);
        rep_last_esc = !rep_char && (r_ridx == r_rcnt - 4'd1) && (r_c == cof_pkg::ESC);
        gen_valid    = act_det || act_pass || rep_step;
        if (act_pass) begin
            gen_byte = i_token.data;
        end else if (rep_step) begin
            gen_byte = rep_char ? r_c : cof_pkg::DETACH_PAT[r_ridx];
        end else begin
            gen_byte = 8'h00;
        end
        tok_end  = (take && !act_replay) || (rep_step && (rep_char || rep_last_esc));
        step_end = tok_end && ((r_state == cof_pkg::BACK_IDLE) ? i_token.eos : r_eos);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cof_pkg::BACK_IDLE: begin
                if (act_replay) begin
                    n_state = cof_pkg::BACK_REPLAY;
                end else if (step_end && gen_valid) begin
                    n_state = cof_pkg::BACK_FLUSH;
                end
            end
            cof_pkg::BACK_REPLAY: begin
                if (tok_end) begin
                    n_state = step_end ? cof_pkg::BACK_FLUSH : cof_pkg::BACK_IDLE;
                end
            end
            cof_pkg::BACK_FLUSH: begin
                if (out_free) begin
                    n_state = cof_pkg::BACK_IDLE;
                end
            end
            default: n_state = cof_pkg::BACK_IDLE;
        endcase
    end

    always_comb begin
        n_dcnt       = r_dcnt;
        n_detached   = r_detached;
        n_c          = r_c;
        n_rcnt       = r_rcnt;
        n_ridx       = r_ridx;
        n_eos        = r_eos;
        n_pend_valid = r_pend_valid;
        n_pend_byte  = r_pend_byte;
        n_pend_det   = r_pend_det;
        out_wr       = 1'b0;
        out_last     = 1'b0;

        // Move the held result out: as last once its request ends, else when displaced.
        if (r_state == cof_pkg::BACK_FLUSH) begin
            if (out_free) begin
                out_wr       = 1'b1;
                out_last     = 1'b1;
                n_pend_valid = 1'b0;
            end
        end else if (gen_valid) begin
            out_wr       = r_pend_valid;
            n_pend_valid = 1'b1;
            n_pend_byte  = gen_byte;
            n_pend_det   = act_det;
        end else if (step_end && r_pend_valid) begin
            out_wr       = 1'b1;
            out_last     = 1'b1;
            n_pend_valid = 1'b0;
        end

        n_out_valid = out_wr ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
        n_out_byte  = out_wr ? r_pend_byte : r_out_byte;
        n_out_det   = out_wr ? r_pend_det : r_out_det;
        n_out_last  = out_wr ? out_last : r_out_last;

        if (act_adv) begin
            n_dcnt = r_dcnt + 4'd1;
        end
        if (act_det) begin
            n_dcnt     = 4'd0;
            n_detached = 1'b1;
        end
        if (act_replay) begin
            n_dcnt = 4'd0;
            n_c    = i_token.data;
            n_rcnt = r_dcnt;
            n_ridx = 4'd0;
            n_eos  = i_token.eos;
        end
        if (rep_step) begin
            if (rep_last_esc) begin
                n_dcnt = 4'd1;
            end else if (!rep_char) begin
                n_ridx = r_ridx + 4'd1;
            end
        end

        o_pop         = take;
        o_out_valid   = r_out_valid;
        o_out_byte    = r_out_byte;
        o_detach_seen = r_out_det;
        o_last_of_run = r_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= cof_pkg::BACK_IDLE;
            r_dcnt       <= 4'd0;
            r_detached   <= 1'b0;
            r_rcnt       <= 4'd0;
            r_ridx       <= 4'd0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_dcnt       <= n_dcnt;
            r_detached   <= n_detached;
            r_rcnt       <= n_rcnt;
            r_ridx       <= n_ridx;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c         <= n_c;
        r_eos       <= n_eos;
        r_pend_byte <= n_pend_byte;
        r_pend_det  <= n_pend_det;
        r_out_byte  <= n_out_byte;
        r_out_det   <= n_out_det;
        r_out_last  <= n_out_last;
    end

endmodule

`default_nettype wire

>>> design/console_output_filter.sv
// console_output_filter: top level of the two-stage terminal output filter.
// Instantiates cof_front, cof_queue and cof_back; depends on cof_pkg.
//
//   Channel | Handshake                 | Payload
//   --------+---------------------------+--------------------------------------------
//   in      | i_in_valid / o_in_ready   | i_in_byte[7:0], i_end_of_read
//   out     | o_out_valid / i_out_ready | o_out_byte[7:0], o_detach_seen, o_last_of_run
//
// Flow: each accepted request queues one token per byte the wrap stage releases
//   (at least one, up to five). The detach stage takes queued bytes one at a time; a
//   mismatch replays the held prefix (up to 15 bytes) plus the breaking byte unless
//   it is ESC, and a request whose last byte gives a result needs a closing step.
// Reset: synchronous, active low; clears all match counts and the detach flag.
// Stalls: a result held by i_out_ready low freezes the detach stage while the wrap stage
//   goes on until the queue fills. After detach, requests are taken and return nothing.
`default_nettype none

module console_output_filter #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_end_of_read,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_detach_seen,
    output logic            o_last_of_run
);

    cof_pkg::t_token        push_token;
    cof_pkg::t_token        head_token;
    cof_pkg::t_queue_status q_status;
    logic                   push;
    logic                   pop;

    // Front: hold partial wrap-disable matches, swap full ones for wrap-enable.
    cof_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .i_end_of_read (i_end_of_read),
        .i_q_status    (q_status),
        .o_push        (push),
        .o_token       (push_token)
    );

    // Decouple the two stages so each can stall on its own.
    cof_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (push_token),
        .i_pop    (pop),
        .o_data   (head_token),
        .o_status (q_status)
    );

    // Back: match the detach sequence, replay held prefixes, mark each request's last result.
    cof_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_token       (head_token),
        .i_q_status    (q_status),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_detach_seen (o_detach_seen),
        .o_last_of_run (o_last_of_run)
    );

endmodule

`default_nettype wire

>>> design/cof_checker.sv
// cof_port_checker: port-level assertions for console_output_filter.
// Bound to the top level below; depends on nothing else.
`default_nettype none

module cof_port_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_detach_seen,
    input wire logic       o_last_of_run
);

    // The detach report carries a zero byte and closes its request.
    a_detach_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_detach_seen |-> o_out_byte == 8'h00 && o_last_of_run)
        else $error("detach result malformed");

    // Nothing follows a delivered detach report.
    a_silent_after_detach: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_detach_seen |=> !o_out_valid)
        else $error("result after detach");

    // The front stage drops ready in the cycle after it accepts a request.
    a_one_request_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted back to back");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_detach_seen) && $stable(o_last_of_run))
        else $error("stalled result changed");

endmodule

bind console_output_filter cof_port_checker u_cof_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_byte    (o_out_byte),
    .o_detach_seen (o_detach_seen),
    .o_last_of_run (o_last_of_run)
);

`default_nettype wire

>>> tb/cof_checker.sv
// cof_checker: scoreboard for the console output filter; predicts and compares.
// Watches the request and result channels and depends on cof_pkg for the sequences.
module cof_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_end_of_read,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_ready,
    input  wire logic [7:0] i_out_byte,
    input  wire logic       i_detach_seen,
    input  wire logic       i_last_of_run,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_bytes_checked,
    output logic            o_detached
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_RUN_RESULTS = 21;

    typedef struct packed {
        logic [7:0] data;
        logic       detach;
        logic       last;
    } t_filtered;

    t_filtered  terminal_bytes[$];   // expected results, oldest first
    t_filtered  run_bytes[$];        // results of the request being predicted
    logic [2:0] wrap_held;
    logic [3:0] detach_held;
    logic       detached_flag;

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_bytes_checked = 0;
        o_detached      = 1'b0;
        wrap_held       = '0;
        detach_held     = '0;
        detached_flag   = 1'b0;
    end

    function automatic void emit_byte(logic [7:0] b, logic det);
        t_filtered r;
        if (run_bytes.size() >= MAX_RUN_RESULTS) return;
        r.data   = b;
        r.detach = det;
        r.last   = 1'b0;
        run_bytes.push_back(r);
    endfunction

    // Back stage: hold a detach prefix, replay it on a mismatch.
    function automatic void detach_filter(logic [7:0] b);
        int cnt;
        int i;
        if (detached_flag) return;
        cnt = int'(detach_held);
        if (b == cof_pkg::DETACH_PAT[cnt]) begin
            cnt++;
            if (cnt == cof_pkg::DETACH_SEQ_LEN) begin
                detached_flag = 1'b1;
                detach_held   = '0;
                emit_byte(8'h00, 1'b1);
                return;
            end
            detach_held = 4'(cnt);
            return;
        end
        if (cnt > 0) begin
            for (i = 0; i < cnt; i++) emit_byte(cof_pkg::DETACH_PAT[i], 1'b0);
            detach_held = '0;
            if (b == cof_pkg::ESC) begin
                detach_held = 4'd1;
                return;
            end
        end
        emit_byte(b, 1'b0);
    endfunction

    function automatic void wrap_release();
        int i;
        for (i = 0; i < int'(wrap_held); i++) detach_filter(cof_pkg::WRAP_OFF[i]);
        wrap_held = '0;
    endfunction

    // Front stage: swap wrap-off for wrap-on, release partial matches unchanged.
    function automatic void wrap_filter(logic [7:0] b);
        int i;
        if (b == cof_pkg::WRAP_OFF[wrap_held]) begin
            if (int'(wrap_held) == cof_pkg::WRAP_LEN - 1) begin
                wrap_held = '0;
                for (i = 0; i < cof_pkg::WRAP_LEN; i++) detach_filter(cof_pkg::WRAP_ON[i]);
                return;
            end
            wrap_held = wrap_held + 3'd1;
            return;
        end
        if (wrap_held != 0) begin
            wrap_release();
            if (b == cof_pkg::ESC) begin
                wrap_held = 3'd1;
                return;
            end
        end
        detach_filter(b);
    endfunction

    function automatic void predict_request(logic [7:0] b, logic eor);
        t_filtered r;
        if (detached_flag) return;
        run_bytes.delete();
        wrap_filter(b);
        if (eor && !detached_flag) wrap_release();
        if (run_bytes.size() > 0) begin
            r = run_bytes[run_bytes.size() - 1];
            r.last = 1'b1;
            run_bytes[run_bytes.size() - 1] = r;
        end
        foreach (run_bytes[k]) terminal_bytes.push_back(run_bytes[k]);
    endfunction

    function automatic void note_failure(string what, t_filtered want, logic have_want);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            if (have_want)
                $display("%0t: %s: expected %h det %b last %b, got %h det %b last %b",
                         $realtime, what, want.data, want.detach, want.last,
                         i_out_byte, i_detach_seen, i_last_of_run);
            else
                $display("%0t: %s: got byte %h detach %b last %b", $realtime, what,
                         i_out_byte, i_detach_seen, i_last_of_run);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_filtered want;
        if (!i_rst_n) begin
            wrap_held     = '0;
            detach_held   = '0;
            detached_flag = 1'b0;
            terminal_bytes.delete();
        end else begin
            // Compare first: a result in this edge cannot come from a request in it.
            if (i_out_valid && i_out_ready) begin
                o_bytes_checked++;
                if (terminal_bytes.size() == 0) begin
                    want = '0;
                    note_failure("unexpected result", want, 1'b0);
                end else begin
                    want = terminal_bytes.pop_front();
                    if (want.data != i_out_byte || want.detach != i_detach_seen
                            || want.last != i_last_of_run)
                        note_failure("result mismatch", want, 1'b1);
                end
            end
            if (i_in_valid && i_in_ready) predict_request(i_in_byte, i_end_of_read);
        end
        o_pending  = terminal_bytes.size();
        o_detached = detached_flag;
    end

endmodule

>>> tb/tb_console_output_filter.sv
// tb_console_output_filter: stimulus and verdict for the console output filter.
// Drives requests with random idling, instantiates the block and cof_checker.
module tb_console_output_filter;
    timeunit 1ns;
    timeprecision 1ps;

    // Longest stretch of cycles with no request or result accepted.
    localparam int STALL_LIMIT = 3000;
    // Cycles to let the block settle after the last expected result.
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_REQUESTS = 125;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [7:0] in_byte = 8'h00;
    logic       in_end_of_read = 1'b0;
    logic       out_ready = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       detach_seen;
    logic       last_of_run;

    int fail_count;
    int pending;
    int bytes_checked;
    logic detached;

    int send_idle = 0;      // percent of cycles the sender holds off
    int recv_idle = 0;      // percent of cycles the receiver stalls
    int requests_accepted = 0;
    int stall_cycles = 0;

    console_output_filter DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_in_byte     (in_byte),
        .i_end_of_read (in_end_of_read),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_out_byte    (out_byte),
        .o_detach_seen (detach_seen),
        .o_last_of_run (last_of_run)
    );

    cof_checker checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_in_byte       (in_byte),
        .i_end_of_read   (in_end_of_read),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_out_byte      (out_byte),
        .i_detach_seen   (detach_seen),
        .i_last_of_run   (last_of_run),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_bytes_checked (bytes_checked),
        .o_detached      (detached)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stall the result channel at random, at the rate of the current phase.
    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Abort when neither channel moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else if (stall_cycles + 1 >= STALL_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("console_output_filter test failed");
                $finish;
            end else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // Offer one request; called and returning at a falling edge. Valid stays
    // high from one request to the next unless the sender decides to idle.
    task automatic send_request(input logic [7:0] b, input logic eor);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid       <= 1'b1;
        in_byte        <= b;
        in_end_of_read <= eor;
        do @(posedge i_clk); while (!in_ready);
        requests_accepted++;
        @(negedge i_clk);
    endtask

    // One random chunk of console traffic. Mostly well-formed wrap-off and
    // detach prefixes, so both stages get deep into their matches; the rest
    // is noise and broken sequences. A detach prefix is always broken before
    // it completes, so detach is saved for the end of the run.
    task automatic random_chunk();
        int kind;
        int len;
        int i;
        logic [7:0] b;
        kind = $urandom_range(99);
        if (kind < 35) begin
            // Full wrap-off, sometimes cut by an end of read
            for (i = 0; i < cof_pkg::WRAP_LEN; i++)
                send_request(cof_pkg::WRAP_OFF[i], $urandom_range(11) == 0);
        end else if (kind < 60) begin
            // Detach prefix, then a byte that breaks it (ESC restarts it)
            len = $urandom_range(cof_pkg::DETACH_SEQ_LEN - 1, 1);
            for (i = 0; i < len; i++)
                send_request(cof_pkg::DETACH_PAT[i], $urandom_range(7) == 0);
            b = ($urandom_range(2) == 0) ? cof_pkg::ESC : 8'($urandom_range(255));
            if (b == cof_pkg::DETACH_PAT[len]) b = ~b;
            send_request(b, $urandom_range(3) == 0);
        end else if (kind < 70) begin
            // Truncated wrap-off followed by a mismatching byte
            len = $urandom_range(cof_pkg::WRAP_LEN - 1, 1);
            for (i = 0; i < len; i++)
                send_request(cof_pkg::WRAP_OFF[i], $urandom_range(7) == 0);
            b = ($urandom_range(2) == 0) ? cof_pkg::ESC : 8'($urandom_range(255));
            if (b == cof_pkg::WRAP_OFF[len]) b = ~b;
            send_request(b, $urandom_range(3) == 0);
        end else begin
            len = $urandom_range(4, 1);
            for (i = 0; i < len; i++)
                send_request(8'($urandom_range(255)), $urandom_range(5) == 0);
        end
    endtask

    initial begin : stimulus
        int i;
        int phase_end;

        // Hold reset, then release at a falling edge.
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: byte extremes and alternating bit patterns
        send_request(8'h00, 1'b1);
        send_request(8'hFF, 1'b0);
        send_request(8'hAA, 1'b0);
        send_request(8'h55, 1'b1);
        // Full wrap-off, rewritten to wrap-on
        for (i = 0; i < cof_pkg::WRAP_LEN; i++)
            send_request(cof_pkg::WRAP_OFF[i], i == cof_pkg::WRAP_LEN - 1);
        // Partial wrap-off at the end of a read, passed on unchanged
        for (i = 0; i < 3; i++) send_request(cof_pkg::WRAP_OFF[i], i == 2);
        // Wrap mismatch on ESC: release the held ESC and restart
        send_request(cof_pkg::ESC, 1'b0);
        send_request(cof_pkg::ESC, 1'b0);
        send_request("x", 1'b1);
        // Detach prefix broken by a plain byte: replay the prefix
        for (i = 0; i < 4; i++) send_request(cof_pkg::DETACH_PAT[i], 1'b0);
        send_request("q", 1'b1);
        // Detach prefix broken by ESC: replay, then restart the match
        send_request(cof_pkg::ESC, 1'b0);
        send_request(cof_pkg::DETACH_PAT[1], 1'b0);
        send_request(cof_pkg::ESC, 1'b0);
        send_request("z", 1'b1);

        // Random traffic in three idling phases
        send_idle = 13;
        recv_idle = 64;
        phase_end = requests_accepted + PHASE_REQUESTS;
        while (requests_accepted < phase_end) random_chunk();

        send_idle = 64;
        recv_idle = 13;
        phase_end = requests_accepted + PHASE_REQUESTS;
        while (requests_accepted < phase_end) random_chunk();

        send_idle = 0;
        recv_idle = 0;
        phase_end = requests_accepted + PHASE_REQUESTS;
        while (requests_accepted < phase_end) random_chunk();

        // Detach: clear any partial match, put bytes ahead of the sequence in
        // the same read, let the sequence span two reads, then check that the
        // block stays silent for everything after it.
        send_request("A", 1'b1);
        send_request("B", 1'b0);
        for (i = 0; i < cof_pkg::DETACH_SEQ_LEN; i++)
            send_request(cof_pkg::DETACH_PAT[i], i == 7 || i == cof_pkg::DETACH_SEQ_LEN - 1);
        for (i = 0; i < cof_pkg::WRAP_LEN; i++) send_request(cof_pkg::WRAP_OFF[i], 1'b0);
        send_request(8'hFF, 1'b1);
        in_valid <= 1'b0;

        // Drain: wait for every expected result, then let the block settle.
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Run covered %0d requests and %0d filtered bytes across three idling phases",
                 requests_accepted, bytes_checked);
        $display("Wrap rewrite, read-end release, prefix replay; detach reached: %0b",
                 detached);
        if (fail_count == 0 && pending == 0)
            $display("console_output_filter test passed");
        else
            $display("console_output_filter test failed");
        $finish;
    end

endmodule
